// File: src/vfp_pkg.sv
package vfp_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int DUTY_WIDTH  = 16;
    localparam int ACC_WIDTH   = 40;
    localparam int GAIN_WIDTH  = 16;
    localparam int Q_FRAC      = 8;
    localparam int PROD_WIDTH  = GAIN_WIDTH + ACC_WIDTH;
    localparam int SHIFT_WIDTH = PROD_WIDTH - Q_FRAC;
    localparam int CFG_WIDTH   = 16;
    localparam int IDX_WIDTH   = 3;

    typedef logic signed [ACC_WIDTH-1:0] acc_t;

    localparam acc_t ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam acc_t ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

    typedef enum logic [IDX_WIDTH-1:0] {
        REG_SETPOINT   = 3'd0,
        REG_PROP_GAIN  = 3'd1,
        REG_INTEG_GAIN = 3'd2,
        REG_DERIV_GAIN = 3'd3,
        REG_OUT_MAX    = 3'd4,
        REG_OUT_MIN    = 3'd5
    } reg_idx_t;

    localparam logic [COUNT_WIDTH-1:0] SETPOINT_RST   = COUNT_WIDTH'(100);
    localparam logic [GAIN_WIDTH-1:0]  PROP_GAIN_RST  = GAIN_WIDTH'(1536);
    localparam logic [GAIN_WIDTH-1:0]  INTEG_GAIN_RST = GAIN_WIDTH'(128);
    localparam logic [GAIN_WIDTH-1:0]  DERIV_GAIN_RST = '0;
    localparam logic [DUTY_WIDTH-1:0]  OUT_MAX_RST    = '1;
    localparam logic [DUTY_WIDTH-1:0]  OUT_MIN_RST    = '0;

    // sequencer commands, one step per cycle, except that the duty step waits while the output register is stalled
    typedef struct packed {
        logic load;
        logic mul_p;
        logic fin_p;
        logic mul_i;
        logic fin_i;
        logic mul_d;
        logic fin_d;
        logic sum;
        logic diff;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic out_hold;
    } sts_t;

    function automatic acc_t sat_add(input acc_t a, input acc_t b);
        logic [ACC_WIDTH:0] s;
        s = {a[ACC_WIDTH-1], a} + {b[ACC_WIDTH-1], b};
        if (s[ACC_WIDTH] != s[ACC_WIDTH-1])
            return s[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
        return s[ACC_WIDTH-1:0];
    endfunction

    function automatic acc_t sat_sub(input acc_t a, input acc_t b);
        logic [ACC_WIDTH:0] s;
        s = {a[ACC_WIDTH-1], a} - {b[ACC_WIDTH-1], b};
        if (s[ACC_WIDTH] != s[ACC_WIDTH-1])
            return s[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
        return s[ACC_WIDTH-1:0];
    endfunction

    // drop Q8.8 fraction from a magnitude product, saturate, reapply sign
    function automatic acc_t q88_finish(input logic [PROD_WIDTH-1:0] prod, input logic neg);
        logic [SHIFT_WIDTH-1:0] r;
        logic                   big;
        acc_t                   m;
        r   = prod[PROD_WIDTH-1:Q_FRAC];
        big = |r[SHIFT_WIDTH-1:ACC_WIDTH-1];
        m   = {1'b0, r[ACC_WIDTH-2:0]};
        if (neg)
            return big ? ACC_MIN : -m;
        return big ? ACC_MAX : m;
    endfunction

endpackage

// File: src/velocity_form_pid_speed_top.sv
// Incremental PID speed controller for one motor channel. Each speed_count
// transaction produces one duty transaction, clamped to [out_min, out_max]
// with clamped set when a limit applied. One transaction is processed at a
// time: a single shared 16 x 40 bit multiplier is used in turn for the P,
// I and D gain products, each followed by a scaling step, then the sum,
// difference and duty clamp steps. The result sits in an output register,
// so a new transaction is accepted while it waits to be taken. Gain and
// limit registers are written through the cfg port; the user must write
// them only while no transaction is open, as the block does not enforce it.
module velocity_form_pid_speed_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [vfp_pkg::IDX_WIDTH-1:0]    cfg_index,
    input  logic [vfp_pkg::CFG_WIDTH-1:0]    cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [vfp_pkg::COUNT_WIDTH-1:0]  speed_count,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [vfp_pkg::DUTY_WIDTH-1:0]   duty,
    output logic                             clamped
);
    import vfp_pkg::*;

    cmd_t cmd;
    sts_t sts;

    vfp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .sts      (sts)
    );

    vfp_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .speed_count (speed_count),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .duty        (duty),
        .clamped     (clamped),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

// File: src/vfp_ctrl.sv
module vfp_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output vfp_pkg::cmd_t  cmd,
    input  vfp_pkg::sts_t  sts
);
    import vfp_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_MUL_P = 10'b0000000010,
        S_FIN_P = 10'b0000000100,
        S_MUL_I = 10'b0000001000,
        S_FIN_I = 10'b0000010000,
        S_MUL_D = 10'b0000100000,
        S_FIN_D = 10'b0001000000,
        S_SUM   = 10'b0010000000,
        S_DIFF  = 10'b0100000000,
        S_DUTY  = 10'b1000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_MUL_P;
            S_MUL_P: state_next = S_FIN_P;
            S_FIN_P: state_next = S_MUL_I;
            S_MUL_I: state_next = S_FIN_I;
            S_FIN_I: state_next = S_MUL_D;
            S_MUL_D: state_next = S_FIN_D;
            S_FIN_D: state_next = S_SUM;
            S_SUM:   state_next = S_DIFF;
            S_DIFF:  state_next = S_DUTY;
            S_DUTY:  if (!sts.out_hold) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign cmd.load  = (state_reg == S_IDLE) && in_valid;
    assign cmd.mul_p = (state_reg == S_MUL_P);
    assign cmd.fin_p = (state_reg == S_FIN_P);
    assign cmd.mul_i = (state_reg == S_MUL_I);
    assign cmd.fin_i = (state_reg == S_FIN_I);
    assign cmd.mul_d = (state_reg == S_MUL_D);
    assign cmd.fin_d = (state_reg == S_FIN_D);
    assign cmd.sum   = (state_reg == S_SUM);
    assign cmd.diff  = (state_reg == S_DIFF);
    assign cmd.emit  = (state_reg == S_DUTY) && !sts.out_hold;

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state register not one-hot");

    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_MUL_P))
        else $error("accepted transaction did not start the sequence");

    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (state_reg == S_IDLE))
        else $error("sequence did not return to idle after result");

    a_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUTY) && sts.out_hold |=> (state_reg == S_DUTY))
        else $error("result step left while output register occupied");

endmodule

// File: src/vfp_dp.sv
module vfp_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [vfp_pkg::IDX_WIDTH-1:0]        cfg_index,
    input  logic [vfp_pkg::CFG_WIDTH-1:0]        cfg_data,
    input  logic [vfp_pkg::COUNT_WIDTH-1:0]      speed_count,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [vfp_pkg::DUTY_WIDTH-1:0]       duty,
    output logic                                 clamped,
    input  vfp_pkg::cmd_t                        cmd,
    output vfp_pkg::sts_t                        sts
);
    import vfp_pkg::*;

    localparam int ND_WIDTH = ACC_WIDTH + 2;

    logic [COUNT_WIDTH-1:0] setpoint_reg;
    logic [GAIN_WIDTH-1:0]  prop_gain_reg;
    logic [GAIN_WIDTH-1:0]  integ_gain_reg;
    logic [GAIN_WIDTH-1:0]  deriv_gain_reg;
    logic [DUTY_WIDTH-1:0]  out_max_reg;
    logic [DUTY_WIDTH-1:0]  out_min_reg;

    acc_t                   integ_reg;
    acc_t                   prev_p_reg;
    acc_t                   prev_presat_reg;
    logic [DUTY_WIDTH-1:0]  held_duty_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;

    acc_t                   op_reg;
    logic [PROD_WIDTH-1:0]  prod_reg;
    logic                   neg_reg;
    acc_t                   p_reg;
    acc_t                   s_reg;
    acc_t                   d_reg;
    acc_t                   presat_reg;
    acc_t                   diff_reg;
    logic                   clamped_reg;

    logic [COUNT_WIDTH:0]   err;
    acc_t                   err_ext;
    logic [ACC_WIDTH-1:0]   op_mag;
    logic [GAIN_WIDTH-1:0]  gain;
    acc_t                   fin;
    logic signed [ND_WIDTH-1:0] nd;
    logic signed [ND_WIDTH-1:0] max_ext;
    logic signed [ND_WIDTH-1:0] min_ext;
    logic [DUTY_WIDTH-1:0]  duty_next;
    logic                   clamped_next;

    assign err     = {1'b0, setpoint_reg} - {1'b0, speed_count};
    assign err_ext = {{(ACC_WIDTH-COUNT_WIDTH-1){err[COUNT_WIDTH]}}, err};
    assign op_mag  = op_reg[ACC_WIDTH-1] ? (~op_reg + 1'b1) : op_reg;
    assign fin     = q88_finish(prod_reg, neg_reg);

    always_comb
    begin
        priority if (cmd.mul_p)
            gain = prop_gain_reg;
        else if (cmd.mul_i)
            gain = integ_gain_reg;
        else
            gain = deriv_gain_reg;
    end

    assign nd      = {{(ND_WIDTH-DUTY_WIDTH){1'b0}}, held_duty_reg}
                   - {{2{diff_reg[ACC_WIDTH-1]}}, diff_reg};
    assign max_ext = {{(ND_WIDTH-DUTY_WIDTH){1'b0}}, out_max_reg};
    assign min_ext = {{(ND_WIDTH-DUTY_WIDTH){1'b0}}, out_min_reg};

    always_comb
    begin
        priority if (nd > max_ext)
        begin
            duty_next    = out_max_reg;
            clamped_next = 1'b1;
        end
        else if (nd < min_ext)
        begin
            duty_next    = out_min_reg;
            clamped_next = 1'b1;
        end
        else
        begin
            duty_next    = nd[DUTY_WIDTH-1:0];
            clamped_next = 1'b0;
        end
    end

    assign out_valid_next = cmd.emit || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg    <= SETPOINT_RST;
            prop_gain_reg   <= PROP_GAIN_RST;
            integ_gain_reg  <= INTEG_GAIN_RST;
            deriv_gain_reg  <= DERIV_GAIN_RST;
            out_max_reg     <= OUT_MAX_RST;
            out_min_reg     <= OUT_MIN_RST;
            integ_reg       <= '0;
            prev_p_reg      <= '0;
            prev_presat_reg <= '0;
            held_duty_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_SETPOINT:   setpoint_reg   <= cfg_data[COUNT_WIDTH-1:0];
                    REG_PROP_GAIN:  prop_gain_reg  <= cfg_data[GAIN_WIDTH-1:0];
                    REG_INTEG_GAIN: integ_gain_reg <= cfg_data[GAIN_WIDTH-1:0];
                    REG_DERIV_GAIN: deriv_gain_reg <= cfg_data[GAIN_WIDTH-1:0];
                    REG_OUT_MAX:    out_max_reg    <= cfg_data[DUTY_WIDTH-1:0];
                    REG_OUT_MIN:    out_min_reg    <= cfg_data[DUTY_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (cmd.fin_i)
            begin
                integ_reg  <= sat_add(integ_reg, fin);
                prev_p_reg <= p_reg;
            end
            if (cmd.diff)
                prev_presat_reg <= presat_reg;
            if (cmd.emit)
                held_duty_reg <= duty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            op_reg <= err_ext;
        else if (cmd.fin_p)
            op_reg <= fin;
        else if (cmd.fin_i)
            op_reg <= sat_sub(p_reg, prev_p_reg);
        if (cmd.mul_p || cmd.mul_i || cmd.mul_d)
        begin
            prod_reg <= gain * op_mag;
            neg_reg  <= op_reg[ACC_WIDTH-1];
        end
        if (cmd.fin_p)
            p_reg <= fin;
        if (cmd.fin_d)
        begin
            s_reg <= sat_add(p_reg, integ_reg);
            d_reg <= fin;
        end
        if (cmd.sum)
            presat_reg <= sat_add(s_reg, d_reg);
        if (cmd.diff)
            diff_reg <= sat_sub(presat_reg, prev_presat_reg);
        if (cmd.emit)
            clamped_reg <= clamped_next;
    end

    assign sts.out_hold = out_valid_reg && out_stall;
    assign out_valid    = out_valid_reg;
    assign duty         = held_duty_reg;
    assign clamped      = clamped_reg;

    a_clamp_val: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && clamped_reg |->
            (held_duty_reg == out_max_reg) || (held_duty_reg == out_min_reg))
        else $error("clamped duty not at a limit");

    a_free_val: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !clamped_reg |->
            (held_duty_reg <= out_max_reg) && (held_duty_reg >= out_min_reg))
        else $error("unclamped duty outside limits");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=>
            out_valid_reg && $stable(held_duty_reg) && $stable(clamped_reg))
        else $error("stalled duty transaction changed or dropped");

endmodule
